// ===== design/bmf_pkg.sv =====
// Package for the box mean filter: sizes, register indexes, sequencer states and
// the record that one divider cell passes to the next.
// Depends on nothing; every other design file uses it.
package bmf_pkg;

    localparam int MAX_WIN    = 9;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int RING_ROWS  = 2 * MAX_WIN;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int RING_W     = $clog2(RING_ROWS);
    localparam int MEM_DEPTH  = RING_ROWS * MAX_WIDTH;
    localparam int ADDR_W     = RING_W + COL_W;
    localparam int QUOT_W     = 8;
    localparam int REM_W      = 17;
    localparam int ACC_W      = 15;

    localparam logic [1:0] REG_WIN_SIZE     = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_LAST,
        ST_ISSUE,
        ST_DIV,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic              valid;
        logic              eof;
        logic [REM_W-1:0]  rem;
        logic [REM_W-1:0]  dvs;
        logic [QUOT_W-1:0] quot;
    } div_beat_t;

endpackage

// ===== design/box_mean_filter_replicate.sv =====
// Box mean filter top level: line store, window sequencer and divider chain.
// An item that releases nothing goes no further than the check state; one that
// releases an output waits while the window is read one pixel a cycle from the single
// line store read port, then the mean passes through eight divider cells. m_tvalid rises
// once the held divider result moves into the output register; a stalled sink adds its wait.
// Reset clears counters, control and configuration (win 3, 1024 x 1024);
// the line store is not cleared and needs no clearing pass.
module box_mean_filter_replicate (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [10:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic        s_tuser,   // [0] mode: 0 pixel, 1 flush tick
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] filtered
    output logic        m_tlast    // end_of_frame
);

    localparam int NCELL = bmf_pkg::QUOT_W;

    // Configuration registers.
    logic [3:0]  win_reg;
    logic [10:0] width_reg;
    logic [10:0] height_reg;

    // Raster position of the next input and the next output pixel. The ring
    // indexes track the row numbers modulo the line store depth in rows.
    logic [bmf_pkg::COL_W-1:0]  in_col_reg;
    logic [bmf_pkg::ROW_W:0]    in_row_reg;
    logic [bmf_pkg::RING_W-1:0] in_ring_reg;
    logic [bmf_pkg::COL_W-1:0]  out_col_reg;
    logic [bmf_pkg::ROW_W-1:0]  out_row_reg;
    logic [bmf_pkg::RING_W-1:0] out_ring_reg;

    bmf_pkg::state_t state_reg;
    bmf_pkg::state_t state_next;

    logic [3:0]                dy_reg;
    logic [3:0]                dx_reg;
    logic [bmf_pkg::ACC_W-1:0] acc_reg;
    logic [7:0]                rd_data_reg;
    logic                      rd_vld_reg;
    logic [7:0]                res_data_reg;
    logic                      res_last_reg;
    logic                      out_valid_reg;
    logic [7:0]                out_data_reg;
    logic                      out_last_reg;

    logic [7:0] line_mem [bmf_pkg::MEM_DEPTH];

    logic        cfg_ok;
    logic [2:0]  pad;
    logic [10:0] last_col;
    logic [10:0] last_row;
    logic        in_accept;
    logic        input_done;
    logic        take_px;
    logic        take_fl;
    logic [10:0] nr_full;
    logic [10:0] nc_full;
    logic [10:0] nr;
    logic [10:0] nc;
    logic        release_ok;
    logic        col_end;
    logic        row_end;
    logic        eof_now;
    logic        last_addr;
    logic        load_out;
    logic [7:0]  area;

    logic signed [12:0] r_s;
    logic signed [12:0] c_s;
    logic [10:0]        r_cl;
    logic [10:0]        c_cl;
    logic signed [12:0] delta;
    logic signed [12:0] ring_s;
    logic signed [12:0] ring_fix;
    logic [bmf_pkg::ADDR_W-1:0] rd_addr;
    logic [bmf_pkg::ADDR_W-1:0] wr_addr;

    bmf_pkg::div_beat_t chain [NCELL+1];

    // A window setting that is even or out of range, or a zero or oversized
    // dimension, freezes the block: items are taken and dropped.
    assign cfg_ok = win_reg[0] && (win_reg >= 4'd3)
                    && ({28'd0, win_reg} <= bmf_pkg::MAX_WIN)
                    && (width_reg != 11'd0) && ({21'd0, width_reg} <= bmf_pkg::MAX_WIDTH)
                    && (height_reg != 11'd0)
                    && ({21'd0, height_reg} <= bmf_pkg::MAX_HEIGHT);
    assign pad      = win_reg[3:1];
    assign last_col = width_reg - 11'd1;
    assign last_row = height_reg - 11'd1;
    assign area     = {4'd0, win_reg} * {4'd0, win_reg};

    assign s_tready   = (state_reg == bmf_pkg::ST_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign input_done = in_row_reg >= height_reg;
    assign take_px    = in_accept && cfg_ok && !s_tuser && !input_done;
    assign take_fl    = in_accept && cfg_ok && s_tuser && input_done;

    // The pending output may go once the bottom-right pixel of its clamped
    // window has arrived; compared row first, then column.
    always_comb
    begin
        nr_full    = {1'b0, out_row_reg} + {8'd0, pad};
        nc_full    = {1'b0, out_col_reg} + {8'd0, pad};
        nr         = (nr_full > last_row) ? last_row : nr_full;
        nc         = (nc_full > last_col) ? last_col : nc_full;
        release_ok = (nr < in_row_reg)
                     || ((nr == in_row_reg) && (nc < {1'b0, in_col_reg}));
    end

    assign col_end = ({1'b0, out_col_reg} + 11'd1) >= width_reg;
    assign row_end = ({1'b0, out_row_reg} + 11'd1) >= height_reg;
    assign eof_now = col_end && row_end;

    // Window address: clamp the row and column to the image, then turn the
    // row offset into a ring index with one wrap either way.
    always_comb
    begin
        r_s = $signed({3'd0, out_row_reg}) + $signed({9'd0, dy_reg})
              - $signed({10'd0, pad});
        c_s = $signed({3'd0, out_col_reg}) + $signed({9'd0, dx_reg})
              - $signed({10'd0, pad});
        if (r_s < 0)
            r_cl = 11'd0;
        else if (r_s > $signed({2'd0, last_row}))
            r_cl = last_row;
        else
            r_cl = r_s[10:0];
        if (c_s < 0)
            c_cl = 11'd0;
        else if (c_s > $signed({2'd0, last_col}))
            c_cl = last_col;
        else
            c_cl = c_s[10:0];
        delta  = $signed({2'd0, r_cl}) - $signed({3'd0, out_row_reg});
        ring_s = $signed({8'd0, out_ring_reg}) + delta;
        if (ring_s < 0)
            ring_fix = ring_s + 13'sd18;
        else if (ring_s >= 13'sd18)
            ring_fix = ring_s - 13'sd18;
        else
            ring_fix = ring_s;
        rd_addr = {ring_fix[bmf_pkg::RING_W-1:0], c_cl[bmf_pkg::COL_W-1:0]};
    end

    assign wr_addr   = {in_ring_reg, in_col_reg};
    assign last_addr = (dy_reg == win_reg - 4'd1) && (dx_reg == win_reg - 4'd1);
    assign load_out  = (state_reg == bmf_pkg::ST_HOLD) && (!out_valid_reg || m_tready);

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bmf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bmf_pkg::ST_IDLE:
            begin
                if (take_px || take_fl)
                    state_next = bmf_pkg::ST_CHECK;
            end
            bmf_pkg::ST_CHECK:
                state_next = release_ok ? bmf_pkg::ST_SUM : bmf_pkg::ST_IDLE;
            bmf_pkg::ST_SUM:
            begin
                if (last_addr)
                    state_next = bmf_pkg::ST_LAST;
            end
            bmf_pkg::ST_LAST:
                state_next = bmf_pkg::ST_ISSUE;
            bmf_pkg::ST_ISSUE:
                state_next = bmf_pkg::ST_DIV;
            bmf_pkg::ST_DIV:
            begin
                if (chain[NCELL].valid)
                    state_next = bmf_pkg::ST_HOLD;
            end
            bmf_pkg::ST_HOLD:
            begin
                if (load_out)
                    state_next = bmf_pkg::ST_IDLE;
            end
            default:
                state_next = bmf_pkg::ST_IDLE;
        endcase
    end

    // Configuration and raster counters. Any register write restarts the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg      <= 4'd3;
            width_reg    <= 11'd1024;
            height_reg   <= 11'd1024;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_ring_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_ring_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bmf_pkg::REG_WIN_SIZE:     win_reg    <= cfg_wdata[3:0];
                bmf_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                bmf_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default:                   win_reg    <= win_reg;
            endcase
            if (cfg_addr inside {bmf_pkg::REG_WIN_SIZE, bmf_pkg::REG_IMAGE_WIDTH,
                                 bmf_pkg::REG_IMAGE_HEIGHT})
            begin
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                in_ring_reg  <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                out_ring_reg <= '0;
            end
        end
        else if (take_px)
        begin
            if (({1'b0, in_col_reg} + 11'd1) >= width_reg)
            begin
                in_col_reg  <= '0;
                in_row_reg  <= in_row_reg + 11'd1;
                in_ring_reg <= (in_ring_reg == 5'd17) ? 5'd0 : in_ring_reg + 5'd1;
            end
            else
                in_col_reg <= in_col_reg + 10'd1;
        end
        else if (state_reg == bmf_pkg::ST_ISSUE)
        begin
            if (eof_now)
            begin
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                in_ring_reg  <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                out_ring_reg <= '0;
            end
            else if (col_end)
            begin
                out_col_reg  <= '0;
                out_row_reg  <= out_row_reg + 10'd1;
                out_ring_reg <= (out_ring_reg == 5'd17) ? 5'd0 : out_ring_reg + 5'd1;
            end
            else
                out_col_reg <= out_col_reg + 10'd1;
        end
    end

    // Line store: one write port for incoming pixels, one registered read port
    // for the window sweep.
    always_ff @(posedge clk)
    begin
        if (take_px)
            line_mem[wr_addr] <= s_tdata;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= line_mem[rd_addr];
    end

    // Window sweep and accumulation; each read lands in the cycle after its address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dy_reg     <= '0;
            dx_reg     <= '0;
            acc_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= (state_reg == bmf_pkg::ST_SUM);
            if (state_reg == bmf_pkg::ST_CHECK)
            begin
                dy_reg  <= '0;
                dx_reg  <= '0;
                acc_reg <= '0;
            end
            else
            begin
                if (state_reg == bmf_pkg::ST_SUM)
                begin
                    if (dx_reg == win_reg - 4'd1)
                    begin
                        dx_reg <= '0;
                        dy_reg <= dy_reg + 4'd1;
                    end
                    else
                        dx_reg <= dx_reg + 4'd1;
                end
                if (rd_vld_reg)
                    acc_reg <= acc_reg + {7'd0, rd_data_reg};
            end
        end
    end

    // Divider chain: floor((2*sum + area) / (2*area)), one quotient bit per cell.
    always_comb
    begin
        chain[0].valid = (state_reg == bmf_pkg::ST_ISSUE);
        chain[0].eof   = eof_now;
        chain[0].rem   = {1'b0, acc_reg, 1'b0} + {9'd0, area};
        chain[0].dvs   = {1'b0, area, 1'b0, 7'd0};
        chain[0].quot  = '0;
    end

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        bmf_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .beat_in  (chain[k]),
            .beat_out (chain[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == bmf_pkg::ST_DIV && chain[NCELL].valid)
        begin
            res_data_reg <= chain[NCELL].quot;
            res_last_reg <= chain[NCELL].eof;
        end
        if (load_out)
        begin
            out_data_reg <= res_data_reg;
            out_last_reg <= res_last_reg;
        end
    end

    // Output register: holds a finished beat until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // The divider only ever delivers a result while the sequencer waits for it.
    a_chain_in_div : assert property (@(posedge clk) disable iff (!rst_n)
        chain[NCELL].valid |-> (state_reg == bmf_pkg::ST_DIV))
        else $error("divider result outside the divide state");

    // The window sweep stays inside the configured window.
    a_sweep_range : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bmf_pkg::ST_SUM) |-> ((dy_reg < win_reg) && (dx_reg < win_reg)))
        else $error("window sweep out of range");

    // A held result moves into an empty output register at once.
    a_hold_moves : assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == bmf_pkg::ST_HOLD) && !out_valid_reg) |=> out_valid_reg)
        else $error("held result not presented");

endmodule

// ===== design/bmf_div_cell.sv =====
// One cell of the divider chain: settles one quotient bit per beat.
// Depends on bmf_pkg.
module bmf_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  bmf_pkg::div_beat_t beat_in,
    output bmf_pkg::div_beat_t beat_out
);

    logic               valid_reg;
    bmf_pkg::div_beat_t data_reg;
    bmf_pkg::div_beat_t data_next;
    logic               fits;

    always_comb
    begin
        fits           = beat_in.rem >= beat_in.dvs;
        data_next      = beat_in;
        data_next.rem  = fits ? beat_in.rem - beat_in.dvs : beat_in.rem;
        data_next.dvs  = beat_in.dvs >> 1;
        data_next.quot = {beat_in.quot[bmf_pkg::QUOT_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= beat_in.valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        beat_out       = data_reg;
        beat_out.valid = valid_reg;
    end

endmodule
